// File: rtl/ccsi_pkg.sv
// ---------------------------------------------------------------------------
// ccsi_pkg: shared types and constants for the CJK spacing inserter
// Job format passed from the byte classifier to the emitter, config
// register indexes and reset values.
// ---------------------------------------------------------------------------
package ccsi_pkg;

	localparam int CP_W        = 21;
	localparam int QUEUE_DEPTH = 2;   // power of two
	localparam int DEF_MAX_SPACE_RUN = 255;

	localparam logic [7:0]      SPACE_CHAR  = 8'h20;
	localparam logic [CP_W-1:0] RST_A_LOW   = 21'h004E00;
	localparam logic [CP_W-1:0] RST_A_HIGH  = 21'h009FFF;
	localparam logic [CP_W-1:0] RST_B_LOW   = 21'h003400;
	localparam logic [CP_W-1:0] RST_B_HIGH  = 21'h004DBF;

	typedef enum logic [1:0] {
		REG_A_LOW  = 2'd0,
		REG_A_HIGH = 2'd1,
		REG_B_LOW  = 2'd2,
		REG_B_HIGH = 2'd3
	} cfg_reg_t;

	// One character's (or stray byte's) worth of output: up to four bytes, spaces ahead of the first
	typedef struct packed {
		logic [2:0]      n;
		logic [7:0]      spaces;
		logic [3:0][7:0] bytes;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: rtl/cjk_char_spacing_inserter_top.sv
// ---------------------------------------------------------------------------
// cjk_char_spacing_inserter_top: UTF-8 CJK space padding
// Pads ideographs with spaces, folds space runs into a count carried on
// the next non-space byte, trims leading and trailing runs.
// ---------------------------------------------------------------------------
// Path: a completing byte's job is written into the job queue, whose head
// the emitter walks a byte at a time.
// Throughput: one input byte per cycle while the queue is not full; one
// result per cycle while out_ready is high and the queue holds a job.
// Reset: arst_n clears decode state and queue; range registers return to
// their default ideograph ranges. No clearing pass.
module cjk_char_spacing_inserter_top import ccsi_pkg::*; #(
	parameter int MAX_SPACE_RUN = DEF_MAX_SPACE_RUN
) (
	input  logic            clk,
	input  logic            arst_n,
	// input byte channel
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            end_of_text,
	// result channel
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic [7:0]      spaces_before,
	output logic            last_of_run,
	// config write channel
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [CP_W-1:0] cfg_data
);

	// front -> queue
	logic      push;
	job_t      job;
	// queue -> back
	job_t      head;
	logic      pop;
	q_status_t q_status;

	// Front: decodes, classifies and builds one job per character or stray byte.
	// It stalls only when the queue is full.
	ccsi_front #(
		.MAX_SPACE_RUN(MAX_SPACE_RUN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.push       (push),
		.job        (job)
	);

	// Two-entry queue decouples the two sides
	ccsi_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(job),
		.pop   (pop),
		.head  (head),
		.status(q_status)
	);

	// Back: one output transaction per job byte
	ccsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.spaces_before(spaces_before),
		.last_of_run  (last_of_run)
	);

`ifndef SYNTHESIS
	// queue can never be full and empty at once
	a_q_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue full and empty together");

	// only jobs carrying bytes enter the queue
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> job.n != 3'd0)
		else $error("empty job pushed");

	// mid-job transaction: the rest of the job follows, with no spaces
	a_job_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> (out_valid && spaces_before == 8'd0))
		else $error("job tail missing or carries spaces");
`endif

endmodule

// File: rtl/ccsi_front.sv
// ---------------------------------------------------------------------------
// ccsi_front: byte classifier and UTF-8 decoder
// Tracks the open sequence, counts spaces, matches ideograph ranges and
// builds one job per character or stray byte. Holds the range registers.
// ---------------------------------------------------------------------------
module ccsi_front import ccsi_pkg::*; #(
	parameter int MAX_SPACE_RUN = DEF_MAX_SPACE_RUN
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            end_of_text,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [CP_W-1:0] cfg_data,
	input  q_status_t       q_status,
	output logic            push,
	output job_t            job
);

	localparam logic [7:0] SPACE_CAP = (MAX_SPACE_RUN > 255) ? 8'd255 : 8'(MAX_SPACE_RUN);

	logic [CP_W-1:0] a_low_q, a_high_q, b_low_q, b_high_q;
	logic [2:0][7:0] seq_q, seq_d;
	logic [2:0]      exp_q, exp_d;
	logic [1:0]      held_q, held_d;
	logic [CP_W-1:0] acc_q, acc_d, acc_shift;
	logic [7:0]      pend_q, pend_d, pend_inc;
	logic            started_q, started_d;
	logic            accept, emit, complete, cjk;

	assign in_ready  = !q_status.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign push      = accept && emit;

	assign pend_inc  = (started_q && pend_q < SPACE_CAP) ? pend_q + 8'd1 : pend_q;
	assign acc_shift = {acc_q[CP_W-7:0], in_byte[5:0]};
	assign complete  = ({1'b0, held_q} + 3'd1) >= exp_q;
	assign cjk = (acc_shift >= a_low_q && acc_shift <= a_high_q) ||
		(acc_shift >= b_low_q && acc_shift <= b_high_q);

	always_comb begin
		job       = '0;
		emit      = 1'b0;
		seq_d     = seq_q;
		exp_d     = exp_q;
		held_d    = held_q;
		acc_d     = acc_q;
		pend_d    = pend_q;
		started_d = started_q;
		if (exp_q == 3'd0) begin
			if (in_byte == SPACE_CHAR) begin
				pend_d = pend_inc;
			end else if (in_byte[7:5] == 3'b110) begin
				exp_d    = 3'd2;
				acc_d    = {16'd0, in_byte[4:0]};
				seq_d[0] = in_byte;
				held_d   = 2'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				exp_d    = 3'd3;
				acc_d    = {17'd0, in_byte[3:0]};
				seq_d[0] = in_byte;
				held_d   = 2'd1;
			end else if (in_byte[7:3] == 5'b11110) begin
				exp_d    = 3'd4;
				acc_d    = {18'd0, in_byte[2:0]};
				seq_d[0] = in_byte;
				held_d   = 2'd1;
			end else begin
				// ASCII or a stray/invalid lead byte: single byte out
				job.n        = 3'd1;
				job.bytes[0] = in_byte;
				job.spaces   = pend_q;
				emit         = 1'b1;
				pend_d       = 8'd0;
				started_d    = 1'b1;
			end
		end else if (complete) begin
			job.n        = {1'b0, held_q} + 3'd1;
			job.spaces   = cjk ? pend_inc : pend_q;
			job.bytes[0] = seq_q[0];
			job.bytes[1] = (held_q >= 2'd2) ? seq_q[1] : in_byte;
			job.bytes[2] = (held_q == 2'd3) ? seq_q[2] : in_byte;
			job.bytes[3] = in_byte;
			emit         = 1'b1;
			pend_d       = cjk ? 8'd1 : 8'd0;
			started_d    = 1'b1;
			exp_d        = 3'd0;
			held_d       = 2'd0;
			acc_d        = '0;
		end else begin
			seq_d[held_q] = in_byte;
			held_d        = held_q + 2'd1;
			acc_d         = acc_shift;
		end

		if (end_of_text) begin
			// cut-off sequence goes out raw
			if (exp_d != 3'd0) begin
				job.n        = {1'b0, held_d};
				job.spaces   = pend_q;
				job.bytes[0] = seq_d[0];
				job.bytes[1] = seq_d[1];
				job.bytes[2] = seq_d[2];
				job.bytes[3] = 8'd0;
				emit         = 1'b1;
			end
			exp_d     = 3'd0;
			held_d    = 2'd0;
			acc_d     = '0;
			pend_d    = 8'd0;
			started_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q     <= 3'd0;
			held_q    <= 2'd0;
			acc_q     <= '0;
			pend_q    <= 8'd0;
			started_q <= 1'b0;
		end else if (accept) begin
			exp_q     <= exp_d;
			held_q    <= held_d;
			acc_q     <= acc_d;
			pend_q    <= pend_d;
			started_q <= started_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_low_q  <= RST_A_LOW;
			a_high_q <= RST_A_HIGH;
			b_low_q  <= RST_B_LOW;
			b_high_q <= RST_B_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_A_LOW:  a_low_q  <= cfg_data;
				REG_A_HIGH: a_high_q <= cfg_data;
				REG_B_LOW:  b_low_q  <= cfg_data;
				REG_B_HIGH: b_high_q <= cfg_data;
				default:    a_low_q  <= a_low_q;
			endcase
		end
	end

endmodule

// File: rtl/ccsi_fifo.sv
// ---------------------------------------------------------------------------
// ccsi_fifo: job queue between classifier and emitter
// Small register FIFO, head entry presented directly.
// ---------------------------------------------------------------------------
module ccsi_fifo import ccsi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      wr_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: rtl/ccsi_back.sv
// ---------------------------------------------------------------------------
// ccsi_back: result emitter
// Walks the head job one byte per transaction; spaces ride on the first.
// ---------------------------------------------------------------------------
module ccsi_back import ccsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  q_status_t  q_status,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [7:0] spaces_before,
	output logic       last_of_run
);

	logic [1:0] idx_q;

	assign out_valid     = !q_status.empty;
	assign out_byte      = head.bytes[idx_q];
	assign spaces_before = (idx_q == 2'd0) ? head.spaces : 8'd0;
	assign last_of_run   = {1'b0, idx_q} == (head.n - 3'd1);
	assign pop           = out_valid && out_ready && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
